// ===== sv/ufd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ufd_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_B = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_C = 3'd5;

  localparam int LEN_W = 10;

  // Frame buffer size on the consumer side; longer frames cannot be held
  localparam int FRAME_BUFFER_BYTES = 1024;
  localparam int LEN_LIMIT          = FRAME_BUFFER_BYTES - 8;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam logic [1:0] TYPE_A = 2'd0;
  localparam logic [1:0] TYPE_B = 2'd1;
  localparam logic [1:0] TYPE_C = 2'd2;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  // Work handed from the front to the back
  typedef enum logic [1:0] {
    OP_START,   // header matched, data holds the header word
    OP_DATA,    // payload byte
    OP_CHECK,   // checksum byte, not the last
    OP_LAST     // last checksum byte, close the frame
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [1:0]  mtype;
    logic [31:0] data;
  } q_entry_t;

  typedef logic [31:0] crc_tab_t [256];

  // Reflected CRC-32 of one byte followed by a number of zero bytes
  function automatic crc_tab_t crc_table(input int zeros);
    crc_tab_t    t;
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int k = 0; k < 8 * (zeros + 1); k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      t[i] = c;
    end
    return t;
  endfunction

  function automatic logic usable(input logic [LEN_W-1:0] len);
    return (len != '0) && (int'(len) <= LEN_LIMIT);
  endfunction

endpackage

`default_nettype wire

// ===== sv/ufd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ufd_front import ufd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_byte,
  output logic                       push,
  output q_entry_t                   entry,
  input  wire logic                  full
);

  logic [31:0]      header_a, header_b, header_c;
  logic [LEN_W-1:0] length_a, length_b, length_c;

  phase_t           phase, phase_next;
  logic [23:0]      window, window_next;
  logic [1:0]       fill, fill_next;
  logic [LEN_W-1:0] byte_count, byte_count_next;
  logic [LEN_W-1:0] frame_length, frame_length_next;
  logic [1:0]       frame_type, frame_type_next;

  logic             take;
  logic [31:0]      word;
  logic [LEN_W-1:0] count_inc;
  logic             hit_a, hit_b, hit_c, hit;

  assign in_ready  = !full;
  assign take      = in_valid && in_ready;
  assign word      = {in_byte, window};
  assign count_inc = byte_count + LEN_W'(1);
  assign hit_a     = (word == header_a) && usable(length_a);
  assign hit_b     = (word == header_b) && usable(length_b);
  assign hit_c     = (word == header_c) && usable(length_c);
  assign hit       = hit_a || hit_b || hit_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_a <= '0;
      header_b <= '0;
      header_c <= '0;
      length_a <= '0;
      length_b <= '0;
      length_c <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER_A: header_a <= cfg_data;
        REG_HEADER_B: header_b <= cfg_data;
        REG_HEADER_C: header_c <= cfg_data;
        REG_LENGTH_A: length_a <= cfg_data[LEN_W-1:0];
        REG_LENGTH_B: length_b <= cfg_data[LEN_W-1:0];
        REG_LENGTH_C: length_c <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    phase_next        = phase;
    window_next       = window;
    fill_next         = fill;
    byte_count_next   = byte_count;
    frame_length_next = frame_length;
    frame_type_next   = frame_type;
    if (take) begin
      unique case (phase)
        PH_PAYLOAD: begin
          byte_count_next = count_inc;
          if (count_inc >= frame_length) begin
            phase_next      = PH_CHECK;
            byte_count_next = '0;
          end
        end
        PH_CHECK: begin
          byte_count_next = count_inc;
          if (byte_count[1:0] == 2'd3) begin
            phase_next      = PH_HUNT;
            byte_count_next = '0;
            window_next     = '0;
            fill_next       = '0;
          end
        end
        default: begin
          phase_next = PH_HUNT;
          if (fill != 2'd3) begin
            window_next[8*fill +: 8] = in_byte;
            fill_next                = fill + 2'd1;
          end else if (hit) begin
            phase_next      = PH_PAYLOAD;
            window_next     = '0;
            fill_next       = '0;
            byte_count_next = '0;
            priority if (hit_a) begin
              frame_type_next   = TYPE_A;
              frame_length_next = length_a;
            end else if (hit_b) begin
              frame_type_next   = TYPE_B;
              frame_length_next = length_b;
            end else begin
              frame_type_next   = TYPE_C;
              frame_length_next = length_c;
            end
          end else begin
            window_next = word[31:8];
          end
        end
      endcase
    end
  end

  // Outputs: what goes into the queue for this beat
  always_comb begin
    push        = 1'b0;
    entry.op    = OP_DATA;
    entry.mtype = frame_type;
    entry.data  = {24'd0, in_byte};
    unique case (phase)
      PH_PAYLOAD: begin
        push = take;
      end
      PH_CHECK: begin
        push     = take;
        entry.op = (byte_count[1:0] == 2'd3) ? OP_LAST : OP_CHECK;
      end
      default: begin
        push        = take && (fill == 2'd3) && hit;
        entry.op    = OP_START;
        entry.mtype = frame_type_next;
        entry.data  = word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      window       <= '0;
      fill         <= '0;
      byte_count   <= '0;
      frame_length <= '0;
      frame_type   <= '0;
    end else begin
      phase        <= phase_next;
      window       <= window_next;
      fill         <= fill_next;
      byte_count   <= byte_count_next;
      frame_length <= frame_length_next;
      frame_type   <= frame_type_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ufd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ufd_queue import ufd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire q_entry_t entry,
  output logic          full,
  output logic          valid,
  output q_entry_t      head,
  input  wire logic     pop
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  q_entry_t        mem [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  function automatic logic [PtrW-1:0] advance(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full  = (count == CntW'(DEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= advance(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= advance(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !valid |-> !pop)
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== sv/ufd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ufd_back import ufd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     q_valid,
  input  wire q_entry_t head,
  output logic          pop,
  output logic          out_valid,
  input  wire logic     out_ready,
  output logic          out_kind,
  output logic [1:0]    out_type,
  output logic [7:0]    out_data,
  output logic          out_status
);

  localparam crc_tab_t TAB0 = crc_table(0);
  localparam crc_tab_t TAB1 = crc_table(1);
  localparam crc_tab_t TAB2 = crc_table(2);
  localparam crc_tab_t TAB3 = crc_table(3);

  logic [31:0] crc;
  logic [31:0] rcheck;
  logic [31:0] hdr_x;
  logic [31:0] hdr_crc;
  logic [31:0] byte_crc;
  logic [31:0] rx_check;
  logic        produces;
  logic        out_free;

  assign produces = (head.op == OP_DATA) || (head.op == OP_LAST);
  assign out_free = !out_valid || out_ready;
  assign pop      = q_valid && (!produces || out_free);

  // Header word from the all-ones start: four lookups at once
  assign hdr_x    = ~head.data;
  assign hdr_crc  = TAB3[hdr_x[7:0]] ^ TAB2[hdr_x[15:8]] ^
                    TAB1[hdr_x[23:16]] ^ TAB0[hdr_x[31:24]];
  assign byte_crc = TAB0[crc[7:0] ^ head.data[7:0]] ^ {8'd0, crc[31:8]};
  assign rx_check = {head.data[7:0], rcheck[31:8]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      crc       <= '1;
      rcheck    <= '0;
    end else begin
      if (pop && produces) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        unique case (head.op)
          OP_START: begin
            crc    <= hdr_crc;
            rcheck <= '0;
          end
          OP_DATA:  crc    <= byte_crc;
          OP_CHECK: rcheck <= rx_check;
          OP_LAST: begin
            crc    <= '1;
            rcheck <= '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && produces) begin
      out_type <= head.mtype;
      if (head.op == OP_LAST) begin
        out_kind   <= 1'b1;
        out_data   <= '0;
        out_status <= (~crc != rx_check);
      end else begin
        out_kind   <= 1'b0;
        out_data   <= head.data[7:0];
        out_status <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (pop && produces) |-> (!out_valid || out_ready))
    else $error("result register overwritten while stalled");

  a_beat_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_kind ? (out_data == 8'd0) : !out_status))
    else $error("malformed result beat");
`endif

endmodule

`default_nettype wire

// ===== sv/uart_frame_deframer_crc32.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Header/length/CRC-32 deframer for a received UART byte stream. One byte is
// taken per clock whenever the queue between the front and back ends has
// room, so the sustained rate is one byte per cycle while the output keeps
// up; the back end retires one queue entry per cycle, unless a result waits
// on a stalled output, through CRC table lookups (four for a header word)
// and a result register. Bytes seen while hunting produce nothing; a match
// of the sliding four-byte window against header_a, header_b or header_c
// (in that priority, length zero or above LEN_LIMIT disables a header)
// starts a frame. Each payload byte comes out as a beat with tuser kind 0,
// and after the four little-endian checksum bytes one end-of-frame beat
// (kind 1) carries the status: 0 for a reflected CRC-32 match over header
// plus payload, 1 else. Payload is forwarded as it arrives, so drop it on a
// bad status. Write configuration only while no frame is in flight.
module uart_frame_deframer_crc32 import ufd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,   // [7:0] rx_byte
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [15:0]                m_tdata,   // [7:0] data_byte, [8] frame_status
  output logic [2:0]                 m_tuser    // [0] out_kind, [2:1] msg_type
);

  logic       push;
  q_entry_t   entry;
  logic       full;
  logic       q_valid;
  q_entry_t   head;
  logic       pop;
  logic       out_kind;
  logic [1:0] out_type;
  logic [7:0] out_data;
  logic       out_status;

  ufd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .push      (push),
    .entry     (entry),
    .full      (full)
  );

  ufd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .entry (entry),
    .full  (full),
    .valid (q_valid),
    .head  (head),
    .pop   (pop)
  );

  ufd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (out_kind),
    .out_type   (out_type),
    .out_data   (out_data),
    .out_status (out_status)
  );

  assign m_tdata = {7'd0, out_status, out_data};
  assign m_tuser = {out_type, out_kind};

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ufd_pkg::*;

  localparam int HOLD_OFF     = 16;    // queue plus output stage, with margin
  localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int RANDOM_BYTES = 60;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_BAD    = 1'b1;

  localparam logic [5:0] TYPE_CODES = {TYPE_C, TYPE_B, TYPE_A};

  typedef struct packed {
    logic       kind;
    logic [1:0] mtype;
    logic [7:0] data;
    logic       status;
  } beat_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = '0;   // [7:0] rx_byte
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [15:0]           m_tdata;          // [7:0] data_byte, [8] frame_status
  logic [2:0]            m_tuser;          // [0] out_kind, [2:1] msg_type

  uart_frame_deframer_crc32 u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Deframer mirror: configuration and frame state
  logic [31:0]      hdr [3];
  logic [LEN_W-1:0] len [3];
  logic [23:0]      win;
  logic [1:0]       win_fill;
  phase_t           ph;
  logic [LEN_W-1:0] byte_cnt;
  logic [LEN_W-1:0] flen;
  logic [1:0]       ftype;
  logic [31:0]      crc_run;
  logic [31:0]      chk_got;

  beat_t beats_due [$];
  beat_t head;

  int  mismatches     = 0;
  int  bytes_sent     = 0;
  int  payload_beats  = 0;
  int  frames_good    = 0;
  int  frames_bad     = 0;
  int  frames_by_type [3] = '{0, 0, 0};
  int  rx_hold        = 0;
  int  idle_cycles    = 0;
  bit  quiet          = 1'b0;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    c ^= {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic bit header_live(input logic [LEN_W-1:0] l);
    return (l != '0) && (int'(l) <= LEN_LIMIT);
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 18) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function void clear_hunt();
    win      = '0;
    win_fill = '0;
    ph       = PH_HUNT;
    byte_cnt = '0;
    crc_run  = '1;
    chk_got  = '0;
  endfunction

  // Advance the mirror by one accepted byte and queue any beat it causes
  function void deframe_byte(input logic [7:0] b);
    logic [31:0] word;
    beat_t       out;
    int          hit;
    case (ph)
      PH_PAYLOAD: begin
        crc_run = crc_byte(crc_run, b);
        out = '{kind: KIND_DATA, mtype: ftype, data: b, status: ST_OK};
        beats_due.push_back(out);
        byte_cnt++;
        if (byte_cnt >= flen) begin
          ph       = PH_CHECK;
          byte_cnt = '0;
          chk_got  = '0;
        end
      end
      PH_CHECK: begin
        chk_got |= 32'(b) << (8 * byte_cnt[1:0]);
        byte_cnt++;
        if (byte_cnt >= 4) begin
          out = '{kind: KIND_END, mtype: ftype, data: 8'h00,
                  status: (~crc_run != chk_got) ? ST_BAD : ST_OK};
          beats_due.push_back(out);
          clear_hunt();
        end
      end
      default: begin
        ph = PH_HUNT;
        if (win_fill < 3) begin
          win |= 24'(b) << (8 * win_fill);
          win_fill++;
        end else begin
          word = {b, win};
          hit  = -1;
          // lowest index wins, so scan from the bottom priority up
          for (int i = 2; i >= 0; i--) begin
            if (word == hdr[i] && header_live(len[i])) hit = i;
          end
          if (hit >= 0) begin
            ftype   = TYPE_CODES[2*hit +: 2];
            flen    = len[hit];
            crc_run = '1;
            for (int i = 0; i < 4; i++) crc_run = crc_byte(crc_run, word[8*i +: 8]);
            win      = '0;
            win_fill = '0;
            byte_cnt = '0;
            chk_got  = '0;
            ph       = PH_PAYLOAD;
          end else begin
            win = word[31:8];
          end
        end
      end
    endcase
  endfunction

  function void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endfunction

  // Result side: check every accepted beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (beats_due.size() == 0) begin
        note_mismatch($sformatf("unexpected beat: tuser %h tdata %h", m_tuser, m_tdata));
      end else begin
        head = beats_due.pop_front();
        if (m_tuser[0] !== head.kind || m_tuser[2:1] !== head.mtype ||
            m_tdata[7:0] !== head.data || m_tdata[8] !== head.status) begin
          note_mismatch($sformatf(
            "beat mismatch (exp/got): kind %0d/%0d type %0d/%0d data %02h/%02h status %0d/%0d",
            head.kind, m_tuser[0], head.mtype, m_tuser[2:1], head.data, m_tdata[7:0],
            head.status, m_tdata[8]));
        end
        if (head.kind == KIND_END) begin
          if (head.status == ST_OK) frames_good++;
          else frames_bad++;
          frames_by_type[head.mtype]++;
        end else begin
          payload_beats++;
        end
      end
    end
  end

  // Result side backpressure
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      rx_hold = idle_len() - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles, %0d results outstanding",
               idle_cycles, beats_due.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (!quiet && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
  endtask

  // Close any open frame, drain, then let the pipeline settle with the input idle
  task automatic go_idle();
    while (ph != PH_HUNT) send_byte(8'($urandom));
    wait_for_results();
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic load_config(input logic [31:0] ha, hb, hc, la, lb, lc);
    logic [31:0]          vals [6];
    logic [CFG_IDX_W-1:0] regs [6];
    vals[0] = ha; regs[0] = REG_HEADER_A;
    vals[1] = hb; regs[1] = REG_HEADER_B;
    vals[2] = hc; regs[2] = REG_HEADER_C;
    vals[3] = la; regs[3] = REG_LENGTH_A;
    vals[4] = lb; regs[4] = REG_LENGTH_B;
    vals[5] = lc; regs[5] = REG_LENGTH_C;
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    hdr[0] = ha;
    hdr[1] = hb;
    hdr[2] = hc;
    len[0] = la[LEN_W-1:0];
    len[1] = lb[LEN_W-1:0];
    len[2] = lc[LEN_W-1:0];
  endtask

  // Header, random payload of the latched length, then the checksum
  task automatic send_frame(input int which, input bit corrupt);
    logic [31:0] crc;
    logic [31:0] chk;
    int          n;
    crc = '1;
    for (int i = 0; i < 4; i++) begin
      send_byte(hdr[which][8*i +: 8]);
      crc = crc_byte(crc, hdr[which][8*i +: 8]);
    end
    // give up if the header missed or an earlier match already took over
    if (ph != PH_PAYLOAD || byte_cnt != 0) return;
    n = flen;
    for (int i = 0; i < n; i++) begin
      logic [7:0] b;
      b = 8'($urandom);
      send_byte(b);
      crc = crc_byte(crc, b);
      if ($urandom_range(0, 63) == 0) wait_for_results();
    end
    chk = ~crc;
    if (corrupt) chk ^= 32'h1 << $urandom_range(0, 31);
    for (int i = 0; i < 4; i++) send_byte(chk[8*i +: 8]);
  endtask

  function automatic logic [31:0] pick_length();
    int         r;
    logic [9:0] l;
    r = $urandom_range(0, 11);
    if (r == 0) l = '0;
    else if (r == 1) l = 10'($urandom_range(LEN_LIMIT + 1, 1023));
    else if (r == 2) l = 10'($urandom_range(13, 64));
    else l = 10'($urandom_range(1, 12));
    // junk in the unused upper bits must be ignored
    return ($urandom_range(0, 1) != 0) ? (($urandom & 32'hFFFF_FC00) | 32'(l)) : 32'(l);
  endfunction

  task automatic test_all_disabled();
    // reset headers are zero but lengths are zero too
    repeat (5) send_byte(8'h00);
  endtask

  task automatic test_priority_and_slide();
    go_idle();
    load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                32'd1, 32'd2, 32'hFFFF_FFF9);
    send_byte(8'hA5);
    send_frame(0, 1'b0);
  endtask

  task automatic test_fallback_and_oversize();
    go_idle();
    load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
                32'd0, 32'd2, 32'hFFFF_FFF9);
    // header_c matches here but its length is above the buffer limit
    repeat (4) send_byte(8'h00);
    send_frame(1, 1'b1);
  endtask

  task automatic test_random_traffic();
    int          start;
    int          action;
    int          pick;
    int          n;
    logic [31:0] ha, hb, hc;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      go_idle();
      quiet = ($urandom_range(0, 3) == 0);
      ha = $urandom;
      hb = ($urandom_range(0, 3) == 0) ? ha : $urandom;
      hc = ($urandom_range(0, 5) == 0) ? hb : $urandom;
      load_config(ha, hb, hc, pick_length(), pick_length(), pick_length());
      repeat ($urandom_range(3, 8)) begin
        action = $urandom_range(0, 9);
        pick   = $urandom_range(0, 2);
        if (action == 0 || !header_live(len[pick])) begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
        end else if (action == 1) begin
          // broken header: a prefix and then a stray byte
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) send_byte(hdr[pick][8*i +: 8]);
          send_byte(8'($urandom));
        end else begin
          repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
          send_frame(pick, $urandom_range(0, 4) == 0);
        end
      end
    end
  endtask

  task automatic test_longest_frame();
    logic [31:0] w;
    go_idle();
    quiet = 1'b0;
    w = $urandom;
    // same word everywhere: a is off, b is oversized, so c takes it
    load_config(w, w, w, 32'd0, 32'd1023, 32'(LEN_LIMIT));
    send_byte(8'($urandom));
    send_frame(2, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      hdr[i] = '0;
      len[i] = '0;
    end
    flen  = '0;
    ftype = TYPE_A;
    clear_hunt();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_all_disabled();
    test_priority_and_slide();
    test_fallback_and_oversize();
    test_random_traffic();
    test_longest_frame();

    wait_for_results();
    repeat (HOLD_OFF) @(posedge clk);
    $display("sent %0d bytes; got %0d payload beats, %0d good and %0d bad frame ends",
             bytes_sent, payload_beats, frames_good, frames_bad);
    $display("frames by header a/b/c: %0d/%0d/%0d, mismatches %0d",
             frames_by_type[0], frames_by_type[1], frames_by_type[2], mismatches);
    if (mismatches == 0 && beats_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
